@@ hdl/vrp_pkg.sv @@
package vrp_pkg;

  // Default coordinate format
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 12;

  // Trig register format (Q1.14) and camera register width
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 14;
  localparam int CAM_W     = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5,
    REG_CAM   = 3'd6
  } cfg_reg_t;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE   = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO  = 16'sd0;
  localparam logic [CAM_W-1:0]         CAM_RESET  = 15'd12288;

  // sqrt(3) = 1/tan(30 deg) in Q.16
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  // Depth terms: -(101*w + 20*cam) / (99*w)
  localparam logic signed [7:0] DEPTH_GAIN = 8'sd101;
  localparam logic signed [7:0] DEPTH_BIAS = 8'sd20;
  localparam logic [6:0]        DEPTH_DEN  = 7'd99;
  // Fixed scale of the x/y denominator
  localparam int XY_DEN_SHIFT = 16;

endpackage

@@ hdl/vrp_in_if.sv @@
interface vrp_in_if #(
  parameter int CW = vrp_pkg::COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vertex_x;
  logic signed [CW-1:0] vertex_y;
  logic signed [CW-1:0] vertex_z;

  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

@@ hdl/vrp_out_if.sv @@
interface vrp_out_if #(
  parameter int CW = vrp_pkg::COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] rotated_x;
  logic signed [CW-1:0] rotated_y;
  logic signed [CW-1:0] rotated_z;
  logic signed [CW-1:0] screen_x;
  logic signed [CW-1:0] screen_y;
  logic signed [CW-1:0] depth_value;
  logic                 w_was_zero;

  modport source (output valid, rotated_x, rotated_y, rotated_z, screen_x, screen_y,
                  depth_value, w_was_zero, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, screen_x, screen_y,
                  depth_value, w_was_zero, output ready);
endinterface

@@ hdl/vrp_cfg_if.sv @@
interface vrp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vrp_pkg::CFG_IDX_W-1:0]     index;
  logic [vrp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/vertex_rotate_project.sv @@
// vertex_rotate_project: rotates a vertex about X, Y and Z and projects it.
// Channels: in_ch takes one vertex (x, y, z) per transaction; out_ch returns
// the rotated vertex, the projected vertex and a flag that is set when the
// translated depth w = rotated_z + camera_distance is zero. cfg_ch writes the
// six sine/cosine registers (Q1.14) and the camera distance; it is always
// ready and is meant to be written while no vertex is in flight.
// Throughput: one vertex per cycle while the output is not stalled. Three
// rotation stages, a product stage, a setup stage, then one quotient bit per
// stage for COORD_WIDTH + 2 stages of the perspective divider (three lanes
// side by side), then the output register.
// Reset: all pipeline valid bits clear, registers take the identity rotation
// and a camera distance of 3.0.
// Stall: when out_ch holds a transaction that is not taken, the whole pipeline
// freezes and in_ch.ready drops; nothing is lost or repeated. Empty slots
// keep moving when the output is free.
module vertex_rotate_project #(
  parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = vrp_pkg::FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  vrp_in_if.sink    in_ch,
  vrp_out_if.source out_ch,
  vrp_cfg_if.sink   cfg_ch
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int TF  = vrp_pkg::TRIG_FRAC;
  localparam int P1  = CW + 17;
  localparam int R1  = P1 - TF;
  localparam int P2  = R1 + 17;
  localparam int R2  = P2 - TF;
  localparam int P3  = R2 + 17;
  localparam int R3  = P3 - TF;
  localparam int ZW  = ((CW > 16) ? CW : 16) + 1;
  localparam int PXW = CW + 18;
  localparam int PZW = ZW + 8;
  localparam int MW  = CW + 16;
  localparam int DW  = ZW - 1 + vrp_pkg::XY_DEN_SHIFT;
  localparam int QB  = CW + 2;
  localparam int NW  = MW + F + 1;
  localparam int HW  = NW - QB;
  localparam int CWD = (HW > DW) ? HW : DW;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat_r3(input logic signed [R3-1:0] v);
    logic same;
    same = (&v[R3-1:CW-1]) || !(|v[R3-1:CW-1]);
    if (same) return v[CW-1:0];
    return v[R3-1] ? C_MIN : C_MAX;
  endfunction

  // Configuration registers
  logic signed [15:0] cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r;
  logic [vrp_pkg::CAM_W-1:0] cam_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_x_r <= vrp_pkg::TRIG_ONE;
      sin_x_r <= vrp_pkg::TRIG_ZERO;
      cos_y_r <= vrp_pkg::TRIG_ONE;
      sin_y_r <= vrp_pkg::TRIG_ZERO;
      cos_z_r <= vrp_pkg::TRIG_ONE;
      sin_z_r <= vrp_pkg::TRIG_ZERO;
      cam_r   <= vrp_pkg::CAM_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        vrp_pkg::REG_COS_X: cos_x_r <= $signed(cfg_ch.data);
        vrp_pkg::REG_SIN_X: sin_x_r <= $signed(cfg_ch.data);
        vrp_pkg::REG_COS_Y: cos_y_r <= $signed(cfg_ch.data);
        vrp_pkg::REG_SIN_Y: sin_y_r <= $signed(cfg_ch.data);
        vrp_pkg::REG_COS_Z: cos_z_r <= $signed(cfg_ch.data);
        vrp_pkg::REG_SIN_Z: sin_z_r <= $signed(cfg_ch.data);
        vrp_pkg::REG_CAM:   cam_r   <= cfg_ch.data[vrp_pkg::CAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: pipeline moves unless the output holds a waiting result
  logic out_v_r;
  logic en;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  logic [3:0] sv_r;

  // Stage 1: rotation about X
  logic signed [P1-1:0] s1_ysum, s1_zsum, s1_yrnd, s1_zrnd;
  logic signed [CW-1:0] s1_x_r;
  logic signed [R1-1:0] s1_y1_r, s1_z1_r;

  assign s1_ysum = $signed(in_ch.vertex_y) * cos_x_r - $signed(in_ch.vertex_z) * sin_x_r;
  assign s1_zsum = $signed(in_ch.vertex_y) * sin_x_r + $signed(in_ch.vertex_z) * cos_x_r;
  assign s1_yrnd = s1_ysum + (P1'(1) <<< (TF - 1));
  assign s1_zrnd = s1_zsum + (P1'(1) <<< (TF - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r  <= in_ch.vertex_x;
      s1_y1_r <= s1_yrnd[P1-1:TF];
      s1_z1_r <= s1_zrnd[P1-1:TF];
    end
  end

  // Stage 2: rotation about Y
  logic signed [P2-1:0] s2_xsum, s2_zsum, s2_xrnd, s2_zrnd;
  logic signed [R1-1:0] s2_y1_r;
  logic signed [R2-1:0] s2_x2_r, s2_z2_r;

  assign s2_xsum = s1_x_r * cos_y_r + s1_z1_r * sin_y_r;
  assign s2_zsum = s1_z1_r * cos_y_r - s1_x_r * sin_y_r;
  assign s2_xrnd = s2_xsum + (P2'(1) <<< (TF - 1));
  assign s2_zrnd = s2_zsum + (P2'(1) <<< (TF - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_y1_r <= s1_y1_r;
      s2_x2_r <= s2_xrnd[P2-1:TF];
      s2_z2_r <= s2_zrnd[P2-1:TF];
    end
  end

  // Stage 3: rotation about Z and saturation
  logic signed [P3-1:0] s3_xsum, s3_ysum, s3_xrnd, s3_yrnd;
  logic signed [CW-1:0] s3_rx_r, s3_ry_r, s3_rz_r;

  assign s3_xsum = s2_x2_r * cos_z_r - s2_y1_r * sin_z_r;
  assign s3_ysum = s2_x2_r * sin_z_r + s2_y1_r * cos_z_r;
  assign s3_xrnd = s3_xsum + (P3'(1) <<< (TF - 1));
  assign s3_yrnd = s3_ysum + (P3'(1) <<< (TF - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rx_r <= sat_r3(s3_xrnd[P3-1:TF]);
      s3_ry_r <= sat_r3(s3_yrnd[P3-1:TF]);
      s3_rz_r <= sat_r3(R3'(s2_z2_r));
    end
  end

  // Stage 4: translate depth, projection products
  logic signed [ZW-1:0]  s4_zt;
  logic signed [PXW-1:0] s4_px_r, s4_py_r;
  logic signed [PZW-1:0] s4_pz_r;
  logic signed [ZW-1:0]  s4_zt_r;
  logic [3*CW-1:0]       s4_rot_r;

  assign s4_zt = ZW'(s3_rz_r) + $signed({{(ZW - vrp_pkg::CAM_W){1'b0}}, cam_r});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rot_r <= {s3_rx_r, s3_ry_r, s3_rz_r};
      s4_zt_r  <= s4_zt;
      s4_px_r  <= s3_rx_r * $signed({1'b0, vrp_pkg::SQRT3_Q16});
      s4_py_r  <= s3_ry_r * $signed({1'b0, vrp_pkg::SQRT3_Q16});
      s4_pz_r  <= -(s4_zt * vrp_pkg::DEPTH_GAIN
                   + $signed({1'b0, cam_r}) * vrp_pkg::DEPTH_BIAS);
    end
  end

  // Stage 5: divider setup (magnitudes, range check, first partial remainder)
  logic [ZW-2:0]  s5_az;
  logic           s5_zneg;
  logic [MW-1:0]  s5_mag [3];
  logic           s5_pneg [3];
  logic [DW-1:0]  s5_den [3];
  logic [NW-1:0]  s5_num [3];
  logic           s5_ovf [3];

  assign s5_zneg = s4_zt_r[ZW-1];
  assign s5_az   = s5_zneg ? (ZW-1)'(-s4_zt_r) : (ZW-1)'(s4_zt_r);

  always_comb begin
    s5_pneg[0] = s4_px_r[PXW-1];
    s5_pneg[1] = s4_py_r[PXW-1];
    s5_pneg[2] = s4_pz_r[PZW-1];
    s5_mag[0]  = s5_pneg[0] ? MW'(-s4_px_r) : MW'(s4_px_r);
    s5_mag[1]  = s5_pneg[1] ? MW'(-s4_py_r) : MW'(s4_py_r);
    s5_mag[2]  = s5_pneg[2] ? MW'(-s4_pz_r) : MW'(s4_pz_r);
    s5_den[0]  = {s5_az, {vrp_pkg::XY_DEN_SHIFT{1'b0}}};
    s5_den[1]  = {s5_az, {vrp_pkg::XY_DEN_SHIFT{1'b0}}};
    s5_den[2]  = DW'(s5_az * vrp_pkg::DEPTH_DEN);
    for (int l = 0; l < 3; l++) begin
      s5_num[l] = {s5_mag[l], {(F + 1){1'b0}}};
      s5_ovf[l] = CWD'(s5_num[l][NW-1:QB]) >= CWD'(s5_den[l]);
    end
  end

  // Divider pipeline registers, index 0 is written by stage 5
  logic [DW-1:0]   rem_r  [QB+1][3];
  logic [DW-1:0]   den_r  [QB+1][3];
  logic [QB-1:0]   quo_r  [QB+1][3];
  logic [QB-1:0]   lo_r   [QB+1][3];
  logic            ovf_r  [QB+1][3];
  logic            neg_r  [QB+1][3];
  logic            nzero_r[QB+1][3];
  logic [3*CW-1:0] rot_r  [QB+1];
  logic            wz_r   [QB+1];
  logic [QB:0]     dv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= s4_rot_r;
      wz_r[0]  <= (s4_zt_r == '0);
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l]   <= DW'(s5_num[l][NW-1:QB]);
        den_r[0][l]   <= s5_den[l];
        quo_r[0][l]   <= '0;
        lo_r[0][l]    <= s5_num[l][QB-1:0];
        ovf_r[0][l]   <= s5_ovf[l];
        neg_r[0][l]   <= s5_pneg[l] ^ s5_zneg;
        nzero_r[0][l] <= (s5_mag[l] == '0);
      end
    end
  end

  // One quotient bit per stage, restoring division
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DW:0] trial [3];
    logic        ge    [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_r[k][l], lo_r[k][l][QB-1]};
        ge[l]    = trial[l] >= {1'b0, den_r[k][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rot_r[k+1] <= rot_r[k];
        wz_r[k+1]  <= wz_r[k];
        for (int l = 0; l < 3; l++) begin
          rem_r[k+1][l]   <= ge[l] ? DW'(trial[l] - {1'b0, den_r[k][l]}) : DW'(trial[l]);
          den_r[k+1][l]   <= den_r[k][l];
          quo_r[k+1][l]   <= {quo_r[k][l][QB-2:0], ge[l]};
          lo_r[k+1][l]    <= {lo_r[k][l][QB-2:0], 1'b0};
          ovf_r[k+1][l]   <= ovf_r[k][l];
          neg_r[k+1][l]   <= neg_r[k][l];
          nzero_r[k+1][l] <= nzero_r[k][l];
        end
      end
    end
  end

  // Final: round half away from zero, apply sign, saturate
  logic [QB:0]          fin_inc [3];
  logic [QB-1:0]        fin_rnd [3];
  logic signed [CW-1:0] fin_val [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fin_inc[l] = {1'b0, quo_r[QB][l]} + 1'b1;
      fin_rnd[l] = fin_inc[l][QB:1];
      if (ovf_r[QB][l]) begin
        fin_val[l] = nzero_r[QB][l] ? '0 : (neg_r[QB][l] ? C_MIN : C_MAX);
      end else if (neg_r[QB][l]) begin
        fin_val[l] = (fin_rnd[l] > QB'({1'b1, {(CW-1){1'b0}}})) ? C_MIN
                                                               : CW'(-fin_rnd[l]);
      end else begin
        fin_val[l] = (fin_rnd[l] > QB'(C_MAX)) ? C_MAX : CW'(fin_rnd[l]);
      end
    end
  end

  // Output register
  logic signed [CW-1:0] out_rx_r, out_ry_r, out_rz_r, out_sx_r, out_sy_r, out_sz_r;
  logic                 out_wz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      {out_rx_r, out_ry_r, out_rz_r} <= rot_r[QB];
      out_sx_r <= fin_val[0];
      out_sy_r <= fin_val[1];
      out_sz_r <= fin_val[2];
      out_wz_r <= wz_r[QB];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r    <= '0;
      dv_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      sv_r    <= {sv_r[2:0], in_ch.valid};
      dv_r    <= {dv_r[QB-1:0], sv_r[3]};
      out_v_r <= dv_r[QB];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.rotated_x   = out_rx_r;
  assign out_ch.rotated_y   = out_ry_r;
  assign out_ch.rotated_z   = out_rz_r;
  assign out_ch.screen_x    = out_sx_r;
  assign out_ch.screen_y    = out_sy_r;
  assign out_ch.depth_value = out_sz_r;
  assign out_ch.w_was_zero  = out_wz_r;

  // Checks
  logic signed [ZW-1:0] chk_zt;
  assign chk_zt = ZW'(out_rz_r) + $signed({{(ZW - vrp_pkg::CAM_W){1'b0}}, cam_r});

  a_flag_matches_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_wz_r == (chk_zt == '0)))
    else $error("w_was_zero disagrees with rotated_z + camera_distance");

  a_zero_w_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_wz_r) |->
      ((out_sx_r == C_MAX) || (out_sx_r == C_MIN) || (out_sx_r == '0)))
    else $error("screen_x not saturated on zero w");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_v_r)
    else $error("output valid after reset");

endmodule
